/* src/fewb_pkg.sv */
// ----------------------------------------------------------------------------
// fewb_pkg: shared definitions for the erase-block writeback buffer
// Sizes of the store, the block buffer and the result codes, plus the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package fewb_pkg;

  localparam int PAGE_BYTES      = 4;
  localparam int PAGES_PER_BLOCK = 32;
  localparam int BLOCK_COUNT     = 32;

  localparam int BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;
  localparam int STORE_BYTES = BLOCK_BYTES * BLOCK_COUNT;
  localparam int STORE_WORDS = STORE_BYTES / PAGE_BYTES;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 8;
  localparam int LOC_W  = 13;
  localparam int PDATA_W = 32;
  localparam int WORD_W = DATA_W * PAGE_BYTES;
  localparam int BSEL_W = $clog2(PAGE_BYTES);
  localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
  localparam int BLK_W  = $clog2(BLOCK_COUNT);
  localparam int SW_W   = $clog2(STORE_WORDS);

  typedef enum logic [1:0] {
    KIND_ERASE   = 2'd0,
    KIND_PROGRAM = 2'd1,
    KIND_COMMIT  = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_COMMIT = 1'b1;
  localparam logic MODE_FLASH  = 1'b0;
  localparam logic MODE_EEPROM = 1'b1;

  typedef enum logic [1:0] {
    SW_ERASED = 2'd0,
    SW_PAGE   = 2'd1,
    SW_MERGE  = 2'd2
  } st_wsrc_t;

  typedef struct packed {
    logic     capture;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     emit;
    kind_t    emit_kind;
    logic     emit_last;
    logic     st_rd_load;
    logic     st_we;
    st_wsrc_t st_wsrc;
    logic     bf_rd_rmw;
    logic     bf_we;
    logic     bf_wsrc_merge;
    logic     load_done;
    logic     clr_dirty;
    logic     set_dirty;
    logic     clr_valid;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic mode;
    logic run_last;
    logic hit;
    logic valid_dirty;
    logic page_last;
    logic clear_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* src/fewb_if.sv */
// ----------------------------------------------------------------------------
// fewb channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface fewb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [fewb_pkg::ADDR_W-1:0] address;
  logic [fewb_pkg::DATA_W-1:0] data;
  logic                      run_last;
  modport source (output valid, operation, address, data, run_last, input ready);
  modport sink   (input valid, operation, address, data, run_last, output ready);
endinterface

interface fewb_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [fewb_pkg::LOC_W-1:0]   location;
  logic [fewb_pkg::PDATA_W-1:0] page_data;
  logic                        last;
  modport source (output valid, kind, location, page_data, last, input ready);
  modport sink   (input valid, kind, location, page_data, last, output ready);
endinterface

interface fewb_cfg_if;
  logic valid;
  logic ready;
  logic memory_kind;
  modport source (output valid, memory_kind, input ready);
  modport sink   (input valid, memory_kind, output ready);
endinterface
`default_nettype wire

/* src/fewb_ram.sv */
// ----------------------------------------------------------------------------
// fewb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fewb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/fewb_dp.sv */
// ----------------------------------------------------------------------------
// fewb_dp: datapath of the writeback buffer
// Item registers, block tag and marks, store and buffer RAMs, the word
// counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module fewb_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fewb_pkg::cmd_t   cmd,
  output fewb_pkg::status_t     status,
  fewb_in_if.sink               in_item,
  fewb_out_if.source            result,
  fewb_cfg_if.sink              cfg
);
  import fewb_pkg::*;

  logic              mode;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;
  logic              run_last;
  logic [BLK_W-1:0]  buffered_block;
  logic              buffer_valid;
  logic              buffer_dirty;
  logic [SW_W-1:0]   cnt;

  logic               out_valid;
  kind_t              out_kind;
  logic [LOC_W-1:0]   out_loc;
  logic [PDATA_W-1:0] out_pdata;
  logic               out_last;

  logic [BLK_W-1:0]  addr_blk;
  logic [PG_W-1:0]   pg;
  logic              st_we;
  logic [SW_W-1:0]   st_waddr;
  logic [SW_W-1:0]   st_raddr;
  logic [WORD_W-1:0] st_wdata;
  logic [WORD_W-1:0] st_rdata;
  logic [PG_W-1:0]   bf_waddr;
  logic [PG_W-1:0]   bf_raddr;
  logic [WORD_W-1:0] bf_wdata;
  logic [WORD_W-1:0] bf_rdata;
  logic [WORD_W-1:0] merge_src;
  logic [WORD_W-1:0] merged;
  logic [LOC_W-1:0]  loc_next;
  logic [PDATA_W-1:0] pdata_next;

  assign addr_blk = address[ADDR_W-1 -: BLK_W];
  assign pg       = cnt[PG_W-1:0];

  assign cfg.ready     = 1'b1;
  assign in_item.ready = cmd.capture;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FLASH;
    end else if (cfg.valid) begin
      mode <= cfg.memory_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && in_item.valid) begin
      op       <= in_item.operation;
      address  <= in_item.address;
      data     <= in_item.data;
      run_last <= in_item.run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffered_block <= '0;
      buffer_valid   <= 1'b0;
      buffer_dirty   <= 1'b0;
    end else begin
      if (cmd.load_done) begin
        buffered_block <= addr_blk;
        buffer_valid   <= 1'b1;
      end
      if (cmd.clr_valid) begin
        buffer_valid <= 1'b0;
      end
      if (cmd.set_dirty) begin
        buffer_dirty <= 1'b1;
      end else if (cmd.clr_dirty) begin
        buffer_dirty <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Read-modify-write merge of the item byte into its word.
  assign merge_src = (mode == MODE_EEPROM) ? st_rdata : bf_rdata;
  always_comb begin
    merged = merge_src;
    merged[address[BSEL_W-1:0]*DATA_W +: DATA_W] = data;
  end

  always_comb begin
    unique case (cmd.st_wsrc)
      SW_ERASED: begin
        st_waddr = cnt;
        st_wdata = '1;
      end
      SW_PAGE: begin
        st_waddr = {buffered_block, pg};
        st_wdata = bf_rdata;
      end
      SW_MERGE: begin
        st_waddr = address[ADDR_W-1:BSEL_W];
        st_wdata = merged;
      end
      default: begin
        st_waddr = cnt;
        st_wdata = '1;
      end
    endcase
  end
  assign st_we    = cmd.st_we;
  assign st_raddr = cmd.st_rd_load ? {addr_blk, pg} : address[ADDR_W-1:BSEL_W];

  assign bf_raddr = cmd.bf_rd_rmw ? address[BSEL_W +: PG_W] : pg;
  assign bf_waddr = cmd.bf_wsrc_merge ? address[BSEL_W +: PG_W] : pg;
  assign bf_wdata = cmd.bf_wsrc_merge ? merged : st_rdata;

  fewb_ram #(.WIDTH(WORD_W), .DEPTH(STORE_WORDS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  fewb_ram #(.WIDTH(WORD_W), .DEPTH(PAGES_PER_BLOCK)) u_buf (
    .clk   (clk),
    .we    (cmd.bf_we),
    .waddr (bf_waddr),
    .wdata (bf_wdata),
    .raddr (bf_raddr),
    .rdata (bf_rdata)
  );

  always_comb begin
    pdata_next = '0;
    unique case (cmd.emit_kind)
      KIND_ERASE:   loc_next = LOC_W'(buffered_block);
      KIND_PROGRAM: begin
        loc_next   = LOC_W'({buffered_block, pg});
        pdata_next = PDATA_W'(bf_rdata);
      end
      KIND_COMMIT:  loc_next = '0;
      KIND_DONE:    loc_next = LOC_W'(address) + 1'b1;
      default:      loc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= cmd.emit_kind;
      out_loc   <= loc_next;
      out_pdata <= pdata_next;
      out_last  <= cmd.emit_last;
    end
  end

  assign result.valid     = out_valid;
  assign result.kind      = out_kind;
  assign result.location  = out_loc;
  assign result.page_data = out_pdata;
  assign result.last      = out_last;

  assign status.op          = op;
  assign status.mode        = mode;
  assign status.run_last    = run_last;
  assign status.hit         = buffer_valid && (addr_blk == buffered_block);
  assign status.valid_dirty = buffer_valid && buffer_dirty;
  assign status.page_last   = (pg == PG_W'(PAGES_PER_BLOCK - 1));
  assign status.clear_last  = (cnt == SW_W'(STORE_WORDS - 1));
  assign status.out_free    = !out_valid || result.ready;
endmodule
`default_nettype wire

/* src/fewb_ctrl.sv */
// ----------------------------------------------------------------------------
// fewb_ctrl: sequencing state machine
// Clears the store after reset; steps each transaction through flushing,
// loading, read-modify-write of the addressed word, done and commit results.
// ----------------------------------------------------------------------------
`default_nettype none
module fewb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire fewb_pkg::status_t status,
  output fewb_pkg::cmd_t         cmd
);
  import fewb_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_DECIDE  = 12'b0000_0000_0100,
    S_ERASE   = 12'b0000_0000_1000,
    S_FL_RD   = 12'b0000_0001_0000,
    S_FL_PROG = 12'b0000_0010_0000,
    S_LD_RD   = 12'b0000_0100_0000,
    S_LD_WR   = 12'b0000_1000_0000,
    S_RMW_RD  = 12'b0001_0000_0000,
    S_RMW_WR  = 12'b0010_0000_0000,
    S_DONE    = 12'b0100_0000_0000,
    S_ECOMMIT = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.emit_kind = KIND_ERASE;
    cmd.st_wsrc   = SW_ERASED;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.st_we   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.capture = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.op == OP_COMMIT) begin
          if (status.mode == MODE_EEPROM) begin
            state_next = S_ECOMMIT;
          end else if (status.valid_dirty) begin
            state_next = S_ERASE;
          end else begin
            state_next = S_IDLE;
          end
        end else if (status.mode == MODE_EEPROM || status.hit) begin
          state_next = S_RMW_RD;
        end else if (status.valid_dirty) begin
          state_next = S_ERASE;
        end else begin
          state_next = S_LD_RD;
        end
      end
      S_ERASE: begin
        cmd.emit_kind = KIND_ERASE;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_FL_RD;
        end
      end
      S_FL_RD: begin
        state_next = S_FL_PROG;
      end
      S_FL_PROG: begin
        cmd.emit_kind = KIND_PROGRAM;
        cmd.st_wsrc   = SW_PAGE;
        cmd.emit_last = status.page_last &&
                        (status.op == OP_COMMIT || !status.run_last);
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.st_we = 1'b1;
          if (status.page_last) begin
            cmd.clr_dirty = 1'b1;
            cmd.cnt_clr   = 1'b1;
            if (status.op == OP_COMMIT) begin
              cmd.clr_valid = 1'b1;
              state_next    = S_IDLE;
            end else begin
              state_next = S_LD_RD;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_FL_RD;
          end
        end
      end
      S_LD_RD: begin
        cmd.st_rd_load = 1'b1;
        state_next     = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.bf_we = 1'b1;
        if (status.page_last) begin
          cmd.load_done = 1'b1;
          cmd.clr_dirty = 1'b1;
          state_next    = S_RMW_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_LD_RD;
        end
      end
      S_RMW_RD: begin
        cmd.bf_rd_rmw = 1'b1;
        state_next    = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.bf_rd_rmw = 1'b1;
        cmd.st_wsrc   = SW_MERGE;
        if (status.mode == MODE_EEPROM) begin
          cmd.st_we = 1'b1;
        end else begin
          cmd.bf_we         = 1'b1;
          cmd.bf_wsrc_merge = 1'b1;
          cmd.set_dirty     = 1'b1;
        end
        state_next = status.run_last ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        cmd.emit_kind = KIND_DONE;
        cmd.emit_last = 1'b1;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ECOMMIT: begin
        cmd.emit_kind = KIND_COMMIT;
        cmd.emit_last = 1'b1;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* src/flash_eraseblock_writeback_buffer.sv */
// ----------------------------------------------------------------------------
// flash_eraseblock_writeback_buffer: erase-block read-modify-write buffer
// Buffers one flash erase block for byte writes, or writes an EEPROM-style
// store directly, and reports erase, program, commit and done transactions.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_item (operation, address, data, run_last) and
// results leave on result (kind, location, page_data, last); both channels
// complete a transaction when valid and ready are high at a clock edge. The
// cfg channel writes memory_kind (0 flash, 1 EEPROM) and is always ready; it
// must only be written while the block is idle.
// One item is worked on at a time; in_item.ready is high only in the idle
// state. A write inside the buffered block, or an EEPROM write, passes the
// decide, read and write states before the next item is taken, plus the
// done state if a done result follows. Loading a new block copies 32 pages,
// each a store read and a buffer write; a flush first emits the erase and
// then 32 program results, each page costing one read of the buffer RAM
// and one result slot. An EEPROM commit passes the decide and commit states.
// The result register sits between the two sides: a stalled receiver holds
// the current result and only stops the sequencer when it wants to emit the
// next one. After reset the store is swept to the erased value, one 32-bit
// word per cycle across all 1024 words, during which no item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module flash_eraseblock_writeback_buffer (
  input  wire logic  clk,
  input  wire logic  rst,
  fewb_in_if.sink    in_item,
  fewb_out_if.source result,
  fewb_cfg_if.sink   cfg
);
  import fewb_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t status;

  fewb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the memories, the block tag and the result register.
  fewb_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_item (in_item),
    .result  (result),
    .cfg     (cfg)
  );
endmodule
`default_nettype wire
